### rtl/bsra_pkg.sv
package bsra_pkg;

  localparam int unsigned GROUP_SIZE = 64;
  localparam int unsigned MAX_SLOTS  = 1024;
  localparam int unsigned NUM_GROUPS = MAX_SLOTS / GROUP_SIZE;

  typedef logic [1:0] res_status_t;
  localparam res_status_t ST_OK        = 2'd0;
  localparam res_status_t ST_NO_SLOTS  = 2'd1;
  localparam res_status_t ST_RANGE     = 2'd2;
  localparam res_status_t ST_IGNORED   = 2'd3;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_SLOT_COUNT = 2'd0;
  localparam reg_idx_t REG_CPU_BASE   = 2'd1;
  localparam reg_idx_t REG_GPU_BASE   = 2'd2;
  localparam reg_idx_t REG_STRIDE     = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_PICK,
    S_FREE,
    S_MUL,
    S_ADD,
    S_FIN
  } state_t;

  typedef struct packed {
    logic        load;
    logic        scan;
    logic        take;
    logic        next_group;
    logic        free_step;
    logic        mul;
    logic        add;
    logic        out_load;
    res_status_t out_code;
    logic        out_addr;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic len_bad;
    logic hvalid;
    logic start_oor;
    logic scan_stop;
    logic found;
    logic free_last;
    logic out_busy;
  } dp_sts_t;

  function automatic logic [63:0] ones_mask(input logic [6:0] n);
    logic [63:0] m;
    if (n >= 7'd64) begin
      m = '1;
    end else begin
      m = (64'd1 << n) - 64'd1;
    end
    return m;
  endfunction

  // bit b set when slots b .. b+len-1 are all set in avail
  function automatic logic [63:0] run_map(input logic [63:0] avail, input logic [6:0] len);
    logic [63:0] acc;
    logic [63:0] cur;
    logic [6:0]  off;
    acc = '1;
    cur = avail;
    off = '0;
    for (int k = 0; k < 7; k++) begin
      if (len[k]) begin
        acc = acc & (cur >> off);
        off = off + 7'(1 << k);
      end
      cur = cur & (cur >> (1 << k));
    end
    return acc;
  endfunction

endpackage

### rtl/bsra_ctrl.sv
module bsra_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bsra_pkg::dp_sts_t sts,
  output bsra_pkg::dp_cmd_t cmd
);

  bsra_pkg::state_t      state_r;
  bsra_pkg::state_t      state_nxt;
  bsra_pkg::res_status_t code_r;
  bsra_pkg::res_status_t code_nxt;
  logic                  addr_r;
  logic                  addr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsra_pkg::S_IDLE;
      code_r  <= bsra_pkg::ST_OK;
      addr_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
      addr_r  <= addr_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    addr_nxt  = addr_r;
    in_stall  = 1'b1;
    cmd       = '0;
    cmd.out_code = code_r;
    cmd.out_addr = addr_r;
    case (state_r)
      bsra_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = bsra_pkg::S_DISPATCH;
        end
      end
      bsra_pkg::S_DISPATCH: begin
        addr_nxt = 1'b0;
        if (!sts.is_free) begin
          if (sts.len_bad) begin
            code_nxt  = bsra_pkg::ST_NO_SLOTS;
            state_nxt = bsra_pkg::S_FIN;
          end else begin
            state_nxt = bsra_pkg::S_SCAN;
          end
        end else if (!sts.hvalid) begin
          code_nxt  = bsra_pkg::ST_IGNORED;
          state_nxt = bsra_pkg::S_FIN;
        end else if (sts.start_oor) begin
          code_nxt  = bsra_pkg::ST_RANGE;
          state_nxt = bsra_pkg::S_FIN;
        end else begin
          state_nxt = bsra_pkg::S_FREE;
        end
      end
      bsra_pkg::S_SCAN: begin
        if (sts.scan_stop) begin
          code_nxt  = bsra_pkg::ST_NO_SLOTS;
          state_nxt = bsra_pkg::S_FIN;
        end else begin
          cmd.scan  = 1'b1;
          state_nxt = bsra_pkg::S_PICK;
        end
      end
      bsra_pkg::S_PICK: begin
        if (sts.found) begin
          cmd.take  = 1'b1;
          state_nxt = bsra_pkg::S_MUL;
        end else begin
          cmd.next_group = 1'b1;
          state_nxt      = bsra_pkg::S_SCAN;
        end
      end
      bsra_pkg::S_FREE: begin
        cmd.free_step = 1'b1;
        if (sts.free_last) begin
          code_nxt  = bsra_pkg::ST_OK;
          state_nxt = bsra_pkg::S_FIN;
        end
      end
      bsra_pkg::S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = bsra_pkg::S_ADD;
      end
      bsra_pkg::S_ADD: begin
        cmd.add   = 1'b1;
        code_nxt  = bsra_pkg::ST_OK;
        addr_nxt  = 1'b1;
        state_nxt = bsra_pkg::S_FIN;
      end
      bsra_pkg::S_FIN: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = bsra_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bsra_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### rtl/bsra_dp.sv
module bsra_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bsra_pkg::dp_cmd_t     cmd,
  output bsra_pkg::dp_sts_t     sts,
  input  logic                  in_mode,
  input  logic [6:0]            in_run_length,
  input  logic [9:0]            in_start_slot,
  input  logic                  in_handle_valid,
  input  logic [10:0]           slot_count,
  input  logic [63:0]           cpu_base,
  input  logic [63:0]           gpu_base,
  input  logic [12:0]           slot_stride,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bsra_pkg::res_status_t out_status,
  output logic [9:0]            out_slot_index,
  output logic [63:0]           out_cpu_address,
  output logic [63:0]           out_gpu_address
);

  logic [63:0] map_r [bsra_pkg::NUM_GROUPS];

  logic        mode_r;
  logic [6:0]  len_r;
  logic [9:0]  start_r;
  logic        hv_r;
  logic [4:0]  grp_r;
  logic [63:0] runs_r;
  logic [9:0]  idx_r;
  logic [22:0] prod_r;
  logic [63:0] cpu_r;
  logic [63:0] gpu_r;
  logic        ov_r;
  bsra_pkg::res_status_t os_r;
  logic [9:0]  oi_r;
  logic [63:0] oc_r;
  logic [63:0] og_r;

  logic [10:0] live;
  logic [10:0] first;
  logic [11:0] first_end;
  logic [10:0] usable;
  logic [63:0] avail;
  logic [10:0] run_end;
  logic [11:0] start_len;
  logic [10:0] hi_n;
  logic [10:0] lo_n;
  logic [63:0] fmask;
  logic [5:0]  pe;
  logic [3:0]  gi;

  assign live      = (slot_count > 11'(bsra_pkg::MAX_SLOTS)) ? 11'(bsra_pkg::MAX_SLOTS)
                                                              : slot_count;
  assign first     = {grp_r, 6'd0};
  assign first_end = {1'b0, first} + 12'd64;
  assign gi        = grp_r[3:0];

  always_comb begin
    usable = live - first;
    if (usable > 11'd64) usable = 11'd64;
    avail = map_r[gi] & bsra_pkg::ones_mask(usable[6:0]);
  end

  always_comb begin
    start_len = {2'b0, start_r} + {5'b0, len_r};
    run_end   = (start_len > {1'b0, live}) ? live : start_len[10:0];
    hi_n = (run_end > first) ? (run_end - first) : 11'd0;
    if (hi_n > 11'd64) hi_n = 11'd64;
    lo_n = ({1'b0, start_r} > first) ? ({1'b0, start_r} - first) : 11'd0;
    if (lo_n > 11'd64) lo_n = 11'd64;
    fmask = bsra_pkg::ones_mask(hi_n[6:0]) & ~bsra_pkg::ones_mask(lo_n[6:0]);
  end

  // lowest set bit of the run map
  always_comb begin
    pe = '0;
    for (int b = 63; b >= 0; b--) begin
      if (runs_r[b]) pe = 6'(b);
    end
  end

  always_comb begin
    sts.is_free   = (mode_r == bsra_pkg::MODE_FREE);
    sts.len_bad   = (len_r == 7'd0) || (len_r > 7'd64);
    sts.hvalid    = hv_r;
    sts.start_oor = ({1'b0, start_r} >= live);
    sts.scan_stop = (first >= live);
    sts.found     = |runs_r;
    sts.free_last = ({1'b0, run_end} <= first_end);
    sts.out_busy  = ov_r && out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < bsra_pkg::NUM_GROUPS; g++) map_r[g] <= '1;
    end else if (cmd.take) begin
      map_r[gi] <= map_r[gi] & ~(bsra_pkg::ones_mask(len_r) << pe);
    end else if (cmd.free_step) begin
      map_r[gi] <= map_r[gi] | fmask;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      len_r   <= in_run_length;
      start_r <= in_start_slot;
      hv_r    <= in_handle_valid;
      grp_r   <= (in_mode == bsra_pkg::MODE_FREE) ? {1'b0, in_start_slot[9:6]} : 5'd0;
    end else if (cmd.next_group || cmd.free_step) begin
      grp_r <= grp_r + 5'd1;
    end
    if (cmd.scan) runs_r <= bsra_pkg::run_map(avail, len_r);
    if (cmd.take) idx_r <= {gi, pe};
    if (cmd.mul)  prod_r <= 23'(idx_r * slot_stride);
    if (cmd.add) begin
      cpu_r <= cpu_base + {41'd0, prod_r};
      gpu_r <= gpu_base + {41'd0, prod_r};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.out_load) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      os_r <= cmd.out_code;
      oi_r <= cmd.out_addr ? idx_r : 10'd0;
      oc_r <= cmd.out_addr ? cpu_r : 64'd0;
      og_r <= cmd.out_addr ? gpu_r : 64'd0;
    end
  end

  assign out_valid       = ov_r;
  assign out_status      = os_r;
  assign out_slot_index  = oi_r;
  assign out_cpu_address = oc_r;
  assign out_gpu_address = og_r;

endmodule

### rtl/bitmap_slot_run_allocator.sv
// channel | ports                                   | beat when
// in      | in_valid in_stall in_mode in_run_length | in_valid && !in_stall
//         | in_start_slot in_handle_valid           |
// out     | out_valid out_stall out_status          | out_valid && !out_stall
//         | out_slot_index out_cpu/gpu_address      |
// cfg     | psel penable pwrite paddr pwdata prdata | psel&penable&pwrite
//
// One request at a time. Allocate: dispatch, then a scan and a pick for each
// bitmap group scanned (at most 16 groups), then index*stride, the base adds
// and the load of the result. Free: dispatch, one step per group touched
// (1 to 3), then the result load. Rejected requests go straight to the load.
// Synchronous active-low reset sets all slots free and config to defaults.
// A stalled result holds in the output register; the next input beat is
// taken while it waits, and that item parks until the register drains.
module bitmap_slot_run_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [6:0]  in_run_length,
  input  logic [9:0]  in_start_slot,
  input  logic        in_handle_valid,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [9:0]  out_slot_index,
  output logic [63:0] out_cpu_address,
  output logic [63:0] out_gpu_address,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [10:0] slot_count_r;
  logic [63:0] cpu_base_r;
  logic [63:0] gpu_base_r;
  logic [12:0] stride_r;

  bsra_pkg::reg_idx_t reg_idx;
  logic               wr_en;

  bsra_pkg::dp_cmd_t cmd;
  bsra_pkg::dp_sts_t sts;

  // registers sit at 8-byte spacing
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= 11'd1024;
      cpu_base_r   <= '0;
      gpu_base_r   <= '0;
      stride_r     <= 13'd32;
    end else if (wr_en) begin
      case (reg_idx)
        bsra_pkg::REG_SLOT_COUNT: slot_count_r <= pwdata[10:0];
        bsra_pkg::REG_CPU_BASE:   cpu_base_r   <= pwdata;
        bsra_pkg::REG_GPU_BASE:   gpu_base_r   <= pwdata;
        bsra_pkg::REG_STRIDE:     stride_r     <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bsra_pkg::REG_SLOT_COUNT: prdata = {53'd0, slot_count_r};
      bsra_pkg::REG_CPU_BASE:   prdata = cpu_base_r;
      bsra_pkg::REG_GPU_BASE:   prdata = gpu_base_r;
      bsra_pkg::REG_STRIDE:     prdata = {51'd0, stride_r};
      default:                  prdata = '0;
    endcase
  end

  bsra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsra_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_mode),
    .in_run_length   (in_run_length),
    .in_start_slot   (in_start_slot),
    .in_handle_valid (in_handle_valid),
    .slot_count      (slot_count_r),
    .cpu_base        (cpu_base_r),
    .gpu_base        (gpu_base_r),
    .slot_stride     (stride_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_slot_index  (out_slot_index),
    .out_cpu_address (out_cpu_address),
    .out_gpu_address (out_gpu_address)
  );

endmodule

### tb/sv/tb_bitmap_slot_run_allocator.sv
module tb_bitmap_slot_run_allocator;

  // Expected result of one request
  typedef struct {
    bsra_pkg::res_status_t status;
    logic [9:0]  slot_index;
    logic [63:0] cpu_address;
    logic [63:0] gpu_address;
  } alloc_res_t;

  // Tracks slot ownership and queues the results the block should return.
  class slot_scoreboard;
    logic [63:0] free_map[bsra_pkg::NUM_GROUPS];
    logic [10:0] slot_count;
    logic [63:0] cpu_base;
    logic [63:0] gpu_base;
    logic [12:0] slot_stride;
    alloc_res_t  pending[$];
    int          errors;

    function void reset_state();
      foreach (free_map[g]) free_map[g] = '1;
      slot_count = 11'd1024;
      cpu_base = '0;
      gpu_base = '0;
      slot_stride = 13'd32;
      errors = 0;
    endfunction

    function void write_reg(bsra_pkg::reg_idx_t idx, logic [63:0] v);
      case (idx)
        bsra_pkg::REG_SLOT_COUNT: slot_count = v[10:0];
        bsra_pkg::REG_CPU_BASE:   cpu_base = v;
        bsra_pkg::REG_GPU_BASE:   gpu_base = v;
        bsra_pkg::REG_STRIDE:     slot_stride = v[12:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] low_ones(int n);
      return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    // Work out the result of an accepted request and update the slot map.
    function void note_request(logic mode, logic [6:0] len, logic [9:0] start, logic hv);
      alloc_res_t r;
      int live;
      int first;
      int s;
      logic [63:0] avail;
      logic [63:0] run;
      bit found;
      r = '{bsra_pkg::ST_OK, '0, '0, '0};
      live = (slot_count > bsra_pkg::MAX_SLOTS) ? bsra_pkg::MAX_SLOTS : slot_count;
      found = 0;
      if (mode == bsra_pkg::MODE_ALLOC) begin
        r.status = bsra_pkg::ST_NO_SLOTS;
        if (len != 0 && len <= bsra_pkg::GROUP_SIZE) begin
          run = low_ones(len);
          for (int g = 0; g < bsra_pkg::NUM_GROUPS && !found; g++) begin
            first = g * bsra_pkg::GROUP_SIZE;
            if (first >= live) break;
            avail = free_map[g] & low_ones(live - first);
            for (int b = 0; b + len <= bsra_pkg::GROUP_SIZE && !found; b++) begin
              if (((avail >> b) & run) == run) begin
                free_map[g] &= ~(run << b);
                found = 1;
                r.status = bsra_pkg::ST_OK;
                r.slot_index = 10'(first + b);
                r.cpu_address = cpu_base + 64'(first + b) * 64'(slot_stride);
                r.gpu_address = gpu_base + 64'(first + b) * 64'(slot_stride);
              end
            end
          end
        end
      end else if (!hv) begin
        r.status = bsra_pkg::ST_IGNORED;
      end else if (start >= live) begin
        r.status = bsra_pkg::ST_RANGE;
      end else begin
        for (int i = 0; i < len; i++) begin
          s = start + i;
          if (s >= live) break;
          free_map[s / bsra_pkg::GROUP_SIZE][s % bsra_pkg::GROUP_SIZE] = 1'b1;
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(bsra_pkg::res_status_t st, logic [9:0] idx,
                               logic [63:0] ca, logic [63:0] ga);
      alloc_res_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat: status %0d", st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (idx !== e.slot_index) begin
        $error("slot_index: expected %0d, got %0d", e.slot_index, idx);
        errors++;
      end
      if (ca !== e.cpu_address) begin
        $error("cpu_address: expected %h, got %h", e.cpu_address, ca);
        errors++;
      end
      if (ga !== e.gpu_address) begin
        $error("gpu_address: expected %h, got %h", e.gpu_address, ga);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_mode = 1'b0;
  logic [6:0] in_run_length = '0;
  logic [9:0] in_start_slot = '0;
  logic in_handle_valid = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [9:0] out_slot_index;
  logic [63:0] out_cpu_address;
  logic [63:0] out_gpu_address;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  slot_scoreboard sb;
  bit calm = 0;       // when set, neither side idles
  int quiet_cycles = 0;

  localparam int QUIET_LIMIT = 20000;

  always #5 clk = ~clk;

  bitmap_slot_run_allocator uut (.*);

  // Result side: random stall, check each accepted beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_result(out_status, out_slot_index, out_cpu_address, out_gpu_address);
      end
      out_stall <= !calm && ($urandom_range(99) < 14);
    end
  end

  // Watchdog: cycles with no beat on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL bitmap_slot_run_allocator");
      $finish;
    end
  end

  // Setup + access cycle; the register takes the value at the access edge.
  task automatic write_reg(bsra_pkg::reg_idx_t idx, logic [63:0] v);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 5'(idx) << 3;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // One request beat; idle gaps come before it at random. Valid stays up
  // after the beat until the next call or drain replaces or drops it.
  task automatic send_req(logic mode, logic [6:0] len, logic [9:0] start, logic hv);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_run_length <= len;
    in_start_slot <= start;
    in_handle_valid <= hv;
    do @(posedge clk); while (in_stall);
    sb.note_request(mode, len, start, hv);
  endtask

  // Wait until every result is back, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic random_req(int max_len);
    logic [6:0] len;
    int pick;
    pick = $urandom_range(99);
    if (pick < 3) len = 7'($urandom_range(127));        // includes zero / oversize
    else len = 7'($urandom_range(max_len, 1));
    if ($urandom_range(99) < 55) begin
      send_req(bsra_pkg::MODE_ALLOC, len, 10'($urandom), 1'($urandom));
    end else begin
      send_req(bsra_pkg::MODE_FREE, len, 10'($urandom), ($urandom_range(99) < 90));
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: lengths at the limits, bad lengths, ignored and out-of-range frees
    send_req(bsra_pkg::MODE_ALLOC, 7'd1, 10'd0, 1'b0);
    send_req(bsra_pkg::MODE_ALLOC, 7'd64, 10'h3FF, 1'b1);
    send_req(bsra_pkg::MODE_ALLOC, 7'd0, 10'd0, 1'b1);
    send_req(bsra_pkg::MODE_ALLOC, 7'd65, 10'd0, 1'b1);
    send_req(bsra_pkg::MODE_ALLOC, 7'd127, 10'd0, 1'b1);
    send_req(bsra_pkg::MODE_ALLOC, 7'd63, 10'd0, 1'b1);
    send_req(bsra_pkg::MODE_FREE, 7'd64, 10'd0, 1'b0);
    send_req(bsra_pkg::MODE_FREE, 7'd0, 10'd1, 1'b1);
    send_req(bsra_pkg::MODE_FREE, 7'd2, 10'd1, 1'b1);
    send_req(bsra_pkg::MODE_FREE, 7'd2, 10'd1, 1'b1);          // already free
    send_req(bsra_pkg::MODE_FREE, 7'd127, 10'd60, 1'b1);       // crosses groups
    send_req(bsra_pkg::MODE_FREE, 7'd64, 10'h3FF, 1'b1);       // runs past the end
    send_req(bsra_pkg::MODE_ALLOC, 7'd64, 10'd0, 1'b1);
    drain();
    write_reg(bsra_pkg::REG_SLOT_COUNT, 64'd100);
    write_reg(bsra_pkg::REG_CPU_BASE, 64'hFFFF_FFFF_FFFF_FFF0);
    write_reg(bsra_pkg::REG_GPU_BASE, 64'h8000_0000_0000_0000);
    write_reg(bsra_pkg::REG_STRIDE, 64'd4096);
    send_req(bsra_pkg::MODE_FREE, 7'd1, 10'd100, 1'b1);        // at slot count
    send_req(bsra_pkg::MODE_FREE, 7'd64, 10'd90, 1'b1);
    send_req(bsra_pkg::MODE_ALLOC, 7'd36, 10'd0, 1'b1);        // no free run of 36 below slot count
    send_req(bsra_pkg::MODE_ALLOC, 7'd40, 10'd0, 1'b1);
    drain();
    write_reg(bsra_pkg::REG_SLOT_COUNT, 64'd0);
    write_reg(bsra_pkg::REG_STRIDE, 64'd0);
    send_req(bsra_pkg::MODE_ALLOC, 7'd1, 10'd0, 1'b1);
    send_req(bsra_pkg::MODE_FREE, 7'd1, 10'd0, 1'b1);
    drain();

    // random phases with varied settings
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 5)
        0: write_reg(bsra_pkg::REG_SLOT_COUNT, 64'd1024);
        1: write_reg(bsra_pkg::REG_SLOT_COUNT, 64'd1);
        2: write_reg(bsra_pkg::REG_SLOT_COUNT, 64'($urandom_range(1024, 1)));
        3: write_reg(bsra_pkg::REG_SLOT_COUNT, 64'($urandom_range(2047, 1025)));
        default: write_reg(bsra_pkg::REG_SLOT_COUNT, 64'($urandom_range(200, 1)));
      endcase
      write_reg(bsra_pkg::REG_CPU_BASE, {$urandom, $urandom});
      write_reg(bsra_pkg::REG_GPU_BASE,
                (ph == 3) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom});
      write_reg(bsra_pkg::REG_STRIDE, (ph == 4) ? 64'h1FFF : 64'($urandom_range(4096, 1)));
      calm = (ph == 6);
      for (int n = 0; n < 120; n++) begin
        random_req((n % 4 == 0) ? 64 : 12);
      end
      drain();
    end
    calm = 0;

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS bitmap_slot_run_allocator");
    end else begin
      $display("FAIL bitmap_slot_run_allocator");
    end
    $finish;
  end
endmodule

### files.f
rtl/bsra_pkg.sv
rtl/bsra_ctrl.sv
rtl/bsra_dp.sv
rtl/bitmap_slot_run_allocator.sv
tb/sv/tb_bitmap_slot_run_allocator.sv
